>>> hdl/alis_pkg.sv
package alis_pkg;

  // Width shared by the position, found_index and entry_count fields.
  localparam int FIELD_W = 8;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_LSEARCH = 2'd1,
    CMD_BSEARCH = 2'd2
  } cmd_code_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic [FIELD_W-1:0]        position;
    logic signed [VALUE_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] found_index;
    logic [FIELD_W-1:0] entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture an accepted item
    logic walk;    // issue one downward read of the shift or linear walk
    logic place;   // write the new value and bump the count
    logic bprobe;  // issue the read of the binary search midpoint
    logic bcmp;    // compare the midpoint entry and narrow the range
    logic hit_lin; // record the linear search match
    logic emit;    // load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins_ok;    // incoming insert has a good position and room
    logic walk_more; // walk pointer has not passed its lower bound
    logic walk_pend; // a read of the walk is still in flight
    logic lin_match; // the entry just read equals the key
    logic b_live;    // binary search range is not empty
    logic b_eq;      // midpoint entry equals the key
    logic out_free;  // output register can take a new item
  } dp_stat_t;

endpackage

>>> hdl/alis_ram.sv
module alis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/alis_ctrl.sv
module alis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  input  alis_pkg::dp_stat_t  st,
  output alis_pkg::ctl_cmd_t  cmd,
  output logic                in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_LSCAN,
    S_BPROBE,
    S_BCMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (in_cmd == alis_pkg::CMD_INSERT) begin
            state_nxt = st.ins_ok ? S_SHIFT : S_FIN;
          end else if (in_cmd == alis_pkg::CMD_LSEARCH) begin
            state_nxt = S_LSCAN;
          end else if (in_cmd == alis_pkg::CMD_BSEARCH) begin
            state_nxt = S_BPROBE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        if (st.walk_more) begin
          cmd.walk = 1'b1;
        end else begin
          // The last moved entry is written back in this cycle.
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_LSCAN: begin
        priority if (st.lin_match) begin
          cmd.hit_lin = 1'b1;
          state_nxt   = S_FIN;
        end else if (!st.walk_more && !st.walk_pend) begin
          state_nxt = S_FIN;
        end else begin
          cmd.walk = st.walk_more;
        end
      end
      S_BPROBE: begin
        if (st.b_live) begin
          cmd.bprobe = 1'b1;
          state_nxt  = S_BCMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BCMP: begin
        cmd.bcmp  = 1'b1;
        state_nxt = st.b_eq ? S_FIN : S_BPROBE;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hdl/alis_dpath.sv
module alis_dpath #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alis_pkg::in_item_t  in_data,
  input  logic                out_stall,
  input  alis_pkg::ctl_cmd_t  cmd,
  output alis_pkg::dp_stat_t  st,
  output logic                out_valid,
  output alis_pkg::out_item_t out_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int BW   = CW + 1;
  localparam int CMPW = (CW + 1 > alis_pkg::FIELD_W) ? CW + 1 : alis_pkg::FIELD_W;
  localparam int FW   = alis_pkg::FIELD_W;
  localparam int VW   = alis_pkg::VALUE_W;

  // Held state and per-item working registers.
  logic [CW-1:0]          count_r, count_nxt;
  logic signed [VW-1:0]   key_r, key_nxt;
  logic [CMPW-1:0]        lb_r, lb_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic                   pend_r, pend_nxt;
  logic [CW-1:0]          pend_idx_r, pend_idx_nxt;
  logic                   mode_ins_r, mode_ins_nxt;
  logic [BW-1:0]          lo_r, lo_nxt;
  logic [BW-1:0]          hi_r, hi_nxt;
  logic [CW-1:0]          mid_r, mid_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [CW-1:0]          res_idx_r, res_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  alis_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [CMPW-1:0]        pos_ext;
  logic                   pos_ok;
  logic                   full;
  logic [BW:0]            lohi_sum;
  logic [BW-1:0]          mid_full;
  logic [CW-1:0]          mid_now;
  logic [CW-1:0]          mid_dec;
  logic [CW-1:0]          i_dec;
  logic [CMPW-1:0]        lb_dec;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VW-1:0]          ram_rdata;

  alis_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_ext  = CMPW'(in_data.position);
  assign pos_ok   = (pos_ext != '0) && (pos_ext <= CMPW'(count_r) + 1'b1);
  assign full     = (CMPW'(count_r) >= CMPW'(CAPACITY));

  assign lohi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_full = lohi_sum[BW:1];
  assign mid_now  = mid_full[CW-1:0];
  assign mid_dec  = mid_now - 1'b1;
  assign i_dec    = i_r - 1'b1;
  assign lb_dec   = lb_r - 1'b1;

  // One read port shared by the walk and the binary probe.
  assign ram_re    = cmd.walk | cmd.bprobe;
  assign ram_raddr = cmd.bprobe ? mid_dec[AW-1:0] : i_dec[AW-1:0];

  // Moved entries land one place up; the new value goes in last.
  assign ram_we    = cmd.place | (pend_r & mode_ins_r);
  assign ram_waddr = cmd.place ? lb_dec[AW-1:0] : pend_idx_r[AW-1:0];
  assign ram_wdata = cmd.place ? key_r : ram_rdata;

  always_comb begin
    st.ins_ok    = pos_ok && !full;
    st.walk_more = (CMPW'(i_r) >= lb_r);
    st.walk_pend = pend_r;
    st.lin_match = pend_r && (ram_rdata == key_r);
    st.b_live    = (lo_r <= hi_r);
    st.b_eq      = (ram_rdata == key_r);
    st.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    count_nxt      = count_r;
    key_nxt        = key_r;
    lb_nxt         = lb_r;
    i_nxt          = i_r;
    pend_nxt       = cmd.walk;
    pend_idx_nxt   = pend_idx_r;
    mode_ins_nxt   = mode_ins_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (cmd.load) begin
      key_nxt      = in_data.operand_value;
      mode_ins_nxt = (in_data.command == alis_pkg::CMD_INSERT);
      lb_nxt       = (in_data.command == alis_pkg::CMD_INSERT) ? pos_ext : CMPW'(1);
      i_nxt        = count_r;
      lo_nxt       = BW'(1);
      hi_nxt       = BW'(count_r);
      res_idx_nxt  = '0;
      if (in_data.command == alis_pkg::CMD_INSERT) begin
        priority if (!pos_ok) begin
          res_status_nxt = alis_pkg::ST_BADPOS;
        end else if (full) begin
          res_status_nxt = alis_pkg::ST_FULL;
        end else begin
          res_status_nxt = alis_pkg::ST_OK;
        end
      end else begin
        res_status_nxt = alis_pkg::ST_NOTFOUND;
      end
    end

    if (cmd.walk) begin
      i_nxt        = i_dec;
      pend_idx_nxt = i_r;
    end

    if (cmd.place) begin
      count_nxt = count_r + 1'b1;
    end

    if (cmd.hit_lin) begin
      res_status_nxt = alis_pkg::ST_OK;
      res_idx_nxt    = pend_idx_r;
    end

    if (cmd.bprobe) begin
      mid_nxt = mid_now;
    end

    if (cmd.bcmp) begin
      priority if (ram_rdata == key_r) begin
        res_status_nxt = alis_pkg::ST_OK;
        res_idx_nxt    = mid_r;
      end else if ($signed(ram_rdata) > key_r) begin
        hi_nxt = {1'b0, mid_r} - 1'b1;
      end else begin
        lo_nxt = {1'b0, mid_r} + 1'b1;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = res_status_r;
      out_data_nxt.found_index = FW'(res_idx_r);
      out_data_nxt.entry_count = FW'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    lb_r         <= lb_nxt;
    i_r          <= i_nxt;
    pend_idx_r   <= pend_idx_nxt;
    mode_ins_r   <= mode_ins_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/array_list_insert_and_search.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     alis_pkg::in_item_t  (command, position, value)
// out_      output     out_valid / out_stall   alis_pkg::out_item_t (status, index, count)
//
// One item is worked at a time and each item gives exactly one result item.
// An insert does one RAM read and one write per moved entry, pipelined
// one entry per cycle, then the write of the new value. A rejected insert
// or the unused command goes straight to its result. A linear search does
// at most one RAM read per entry, then a check of the last read.
// Each binary search probe is a read and then a compare, and there are at
// most ceil(log2(count + 1)) probes.
// Reset is synchronous and active low; it empties the list at once. The entry
// storage needs no clearing since no position above the count is ever read.
// A stalled result is held in the output register; the next item is accepted
// while it waits, and its own result is held back until the register frees.
module array_list_insert_and_search #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alis_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output alis_pkg::out_item_t out_data
);

  // The controller sequences each command; the datapath holds the count,
  // the entry RAM, the walk and search pointers and the output register.
  alis_pkg::ctl_cmd_t cmd;
  alis_pkg::dp_stat_t st;

  alis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  alis_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/alis_chk.sv
module alis_chk #(
  parameter int CAPACITY = 128
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input alis_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input alis_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Rejections and misses never report a position.
  a_no_index_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == alis_pkg::ST_BADPOS ||
                  out_data.status == alis_pkg::ST_FULL ||
                  out_data.status == alis_pkg::ST_NOTFOUND)
    |-> out_data.found_index == '0)
    else $error("index reported on a failed request");

  // A full rejection only happens at capacity.
  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == alis_pkg::ST_FULL
    |-> out_data.entry_count == 8'(CAPACITY))
    else $error("store full reported below capacity");

endmodule

bind array_list_insert_and_search alis_chk #(.CAPACITY(CAPACITY)) u_alis_chk (.*);

>>> tb/array_list_insert_and_search_checker.sv
`timescale 1ns / 1ps

module array_list_insert_and_search_checker
  import alis_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results
);

  localparam int MAX_PRINTED = 40;

  // Our own copy of the list contents and length.
  logic signed [VALUE_W-1:0] list_vals [CAPACITY];
  int                        list_len;
  out_item_t                 awaited [$];

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // Highest position holding the key, or zero.
  function automatic logic [FIELD_W-1:0] scan_down(input logic signed [VALUE_W-1:0] key);
    for (int i = list_len; i >= 1; i--) begin
      if (list_vals[i-1] == key) return FIELD_W'(i);
    end
    return '0;
  endfunction

  // Fixed halving probe sequence over positions 1..length, signed compare.
  function automatic logic [FIELD_W-1:0] probe_halves(input logic signed [VALUE_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 1;
    hi = list_len;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (list_vals[mid-1] == key) return FIELD_W'(mid);
      if (list_vals[mid-1] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return '0;
  endfunction

  function automatic out_item_t serve_request(input in_item_t req);
    out_item_t res;
    int        pos;
    res.status      = ST_NOTFOUND;
    res.found_index = '0;
    pos = int'(req.position);
    case (req.command)
      CMD_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          res.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i >= pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos-1] = req.operand_value;
          list_len++;
          res.status = ST_OK;
        end
      end
      CMD_LSEARCH, CMD_BSEARCH: begin
        res.found_index = (req.command == CMD_LSEARCH) ? scan_down(req.operand_value)
                                                       : probe_halves(req.operand_value);
        res.status = (res.found_index != '0) ? ST_OK : ST_NOTFOUND;
      end
      default: ;
    endcase
    res.entry_count = FIELD_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      list_len = 0;
      awaited.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with nothing awaited",
                                    out_data.status, out_data.found_index,
                                    out_data.entry_count));
        end else begin
          want = awaited.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.found_index !== want.found_index)
            report_mismatch($sformatf("found_index got %0d want %0d",
                                      out_data.found_index, want.found_index));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_data.entry_count, want.entry_count));
        end
      end
      if (in_valid && !in_stall) awaited.push_back(serve_request(in_data));
    end
    pending_results <= awaited.size();
  end

endmodule

>>> tb/array_list_insert_and_search_test.sv
`timescale 1ns / 1ps

module array_list_insert_and_search_test;
  import alis_pkg::*;

  localparam int CAPACITY       = 128;
  localparam int RANDOM_ITEMS   = 830;
  // The first two thirds of the random items run under two idling mixes.
  localparam int MIX_B_START    = 280;
  localparam int MIX_C_START    = 560;
  // Long receiver hold-off: far longer than the slowest item, so the block
  // takes one item into its output register, one more into work, and then
  // has to stall its input.
  localparam int HOLD_CYCLES    = 600;
  // The hold-off above is the longest correct stretch with no handshake;
  // the limit is several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int VAL_MAX        = 2147483647;
  localparam int VAL_MIN        = -2147483647 - 1;
  // The command field has one code that the block does not use.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending_results;

  // Idling mix, in percent per cycle. Both are written with nonblocking
  // assignments at the falling edge, where issue and the receiver read them.
  int send_idle_pct = 28;
  int stall_pct = 81;

  // The stimulus side toggles hold_req; the receiver process notices the
  // difference to hold_ack and counts the hold-off itself.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  // List contents as the stimulus expects them to be. This only steers the
  // choice of keys and insert positions; the checker does the predicting.
  int shadow [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  array_list_insert_and_search #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  array_list_insert_and_search_checker #(.CAPACITY(CAPACITY)) list_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // Receiver. A pending hold-off request wins over the random stall; once
  // started, the hold-off runs to its end regardless of anything else.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAIL array_list_insert_and_search");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t req(input logic [1:0] cmd, input int pos, input int val);
    in_item_t item;
    item.command       = cmd;
    item.position      = FIELD_W'(pos);
    item.operand_value = val;
    return item;
  endfunction

  // Position right after the last entry that does not exceed v, so that a
  // sorted list stays sorted and equal keys pile up next to each other.
  function automatic int sorted_slot(input int v);
    for (int i = 0; i < shadow.size(); i++) begin
      if (shadow[i] > v) return i + 1;
    end
    return shadow.size() + 1;
  endfunction

  // Half the keys come from the list itself so that searches hit, and a
  // narrow band around zero gives plenty of duplicates.
  function automatic int pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (shadow.size() > 0 && sel < 5) return shadow[$urandom_range(0, shadow.size() - 1)];
    if (sel < 8) return int'($urandom_range(0, 400)) - 200;
    return int'($urandom);
  endfunction

  // Mostly well-formed traffic: sorted inserts and searches for keys that
  // are likely present. About one item in ten is noise with every field
  // random, which brings bad positions, the unused command and now and
  // then an insert that breaks the ascending order.
  function automatic in_item_t random_request();
    in_item_t item;
    int       roll;
    int       key;
    roll = $urandom_range(0, 99);
    key  = pick_key();
    item.command       = CMD_INSERT;
    item.position      = FIELD_W'($urandom);
    item.operand_value = $urandom;
    if (roll < 10) begin
      item.command = 2'($urandom_range(0, 3));
    end else if (roll < 40) begin
      item.operand_value = key;
      item.position      = FIELD_W'(sorted_slot(key));
    end else begin
      item.command       = (roll < 70) ? CMD_BSEARCH : CMD_LSEARCH;
      item.operand_value = key;
    end
    return item;
  endfunction

  // Mirrors only what the stimulus needs: whether an insert lands.
  function automatic void track_request(input in_item_t item);
    int pos;
    pos = int'(item.position);
    if (item.command == CMD_INSERT && pos >= 1 && pos <= shadow.size() + 1 &&
        shadow.size() < CAPACITY) begin
      shadow.insert(pos - 1, int'(item.operand_value));
    end
  endfunction

  // Called and returning at a falling edge. The item is held unchanged
  // until the rising edge at which the block takes it.
  task automatic issue(input in_item_t item);
    track_request(item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Both searches on an empty list, then rejected inserts
    // (position zero and beyond the end), a sorted list built from the
    // value extremes with a duplicate at the top, hits and misses for both
    // searches, the unused command, and finally an out-of-order entry at
    // the top so that the halving search runs over an unsorted list.
    issue(req(CMD_LSEARCH, 255, 0));
    issue(req(CMD_BSEARCH, 0, VAL_MIN));
    issue(req(CMD_INSERT, 0, 7));
    issue(req(CMD_INSERT, 2, 7));
    issue(req(CMD_INSERT, 1, VAL_MAX));
    issue(req(CMD_INSERT, 1, VAL_MIN));
    issue(req(CMD_INSERT, 2, -1));
    issue(req(CMD_INSERT, 3, 0));
    issue(req(CMD_INSERT, 5, VAL_MAX));
    issue(req(CMD_INSERT, 255, 3));
    issue(req(CMD_INSERT, 7, 3));
    issue(req(CMD_LSEARCH, 0, VAL_MAX));
    issue(req(CMD_BSEARCH, 128, VAL_MAX));
    issue(req(CMD_BSEARCH, 1, VAL_MIN));
    issue(req(CMD_BSEARCH, 2, 1));
    issue(req(CMD_LSEARCH, 3, -1));
    issue(req(CMD_LSEARCH, 4, 12345));
    issue(req(CMD_UNUSED, 128, -1));
    issue(req(CMD_INSERT, 6, -5));
    issue(req(CMD_BSEARCH, 0, -5));
    issue(req(CMD_LSEARCH, 0, -5));
    issue(req(CMD_BSEARCH, 0, 0));

    // Random part. The list fills up partway through, after which inserts
    // with a good position are turned away as full and the rest as bad.
    // The last mix drops all idling and starts with the long hold-off
    // while the sender keeps offering items.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == MIX_B_START) begin
        send_idle_pct <= 81;
        stall_pct     <= 28;
      end
      if (n == MIX_C_START) begin
        send_idle_pct <= 0;
        stall_pct     <= 0;
        hold_req      <= ~hold_req;
      end
      issue(random_request());
    end
    in_valid <= 1'b0;

    // The watchdog covers a result that never comes.
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS array_list_insert_and_search");
    end else begin
      $display("FAIL array_list_insert_and_search");
    end
    $finish;
  end

endmodule
